// File: rtl/lbct_pkg.sv
// ----------------------------------------------------------------------------
// lbct_pkg
// Shared constants, codes and types of the labelled byte counter table.
// ----------------------------------------------------------------------------
package lbct_pkg;

	localparam int CAPACITY  = 64;
	localparam int TAG_BITS  = 8;
	localparam int TAG_DEPTH = 2 ** TAG_BITS;
	localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int USED_W    = $clog2(CAPACITY + 1);
	localparam int CNT_W     = 48;
	localparam int AMT_W     = 32;

	// Job queue between the classifier and the counter update.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_SUB    = 2'd1,
		ACT_QLABEL = 2'd2,
		ACT_QTOTAL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_UNDER = 2'd2
	} status_t;

	// What the back end has to do with a classified item.
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_FULL = 2'd1,
		KIND_SLOT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		action_t           action;
		logic [AMT_W-1:0]  amount;
		logic [SLOT_W-1:0] slot;
		logic              fresh;
	} job_t;

endpackage

// File: rtl/lbct_front.sv
// ----------------------------------------------------------------------------
// lbct_front
// Accepts requests, looks the label up in the label-to-slot map and
// allocates a new slot for a missing label.
// ----------------------------------------------------------------------------
module lbct_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [lbct_pkg::TAG_BITS-1:0]  tag,
	input  logic [lbct_pkg::AMT_W-1:0]     amount,
	output logic                           push,
	output lbct_pkg::job_t                 push_job,
	input  logic                           q_full
);
	import lbct_pkg::*;

	logic              valid_s1;
	action_t           act_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [AMT_W-1:0]  amt_s1;
	logic [SLOT_W-1:0] map_rd_s1;

	logic [SLOT_W-1:0]    map_mem [TAG_DEPTH];
	logic [TAG_DEPTH-1:0] tag_vld_q;
	logic [USED_W-1:0]    used_q;

	logic accept;
	logic hit;
	logic room;
	logic alloc;

	// One request is held at a time, so a map write always lands before
	// the next lookup reads the map.
	assign in_stall = valid_s1;
	assign accept   = in_valid && !valid_s1;
	assign push     = valid_s1 && !q_full;

	always_comb begin
		hit             = tag_vld_q[tag_s1];
		room            = used_q < USED_W'(CAPACITY);
		alloc           = 1'b0;
		push_job.kind   = KIND_PASS;
		push_job.action = act_s1;
		push_job.amount = amt_s1;
		push_job.slot   = map_rd_s1;
		push_job.fresh  = 1'b0;
		priority if (act_s1 == ACT_QTOTAL || (act_s1 == ACT_SUB && amt_s1 == '0)) begin
			push_job.kind = KIND_PASS;
		end else if (hit) begin
			push_job.kind = KIND_SLOT;
		end else if (room) begin
			push_job.kind  = KIND_SLOT;
			push_job.slot  = used_q[SLOT_W-1:0];
			push_job.fresh = 1'b1;
			alloc          = push;
		end else begin
			push_job.kind = KIND_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			tag_vld_q <= '0;
			used_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (alloc) begin
				tag_vld_q[tag_s1] <= 1'b1;
				used_q            <= used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= action_t'(action);
			tag_s1    <= tag;
			amt_s1    <= amount;
			map_rd_s1 <= map_mem[tag];
		end
		if (alloc) begin
			map_mem[tag_s1] <= used_q[SLOT_W-1:0];
		end
	end

endmodule

// File: rtl/lbct_queue.sv
// ----------------------------------------------------------------------------
// lbct_queue
// Short job queue that decouples the classifier from the counter update.
// ----------------------------------------------------------------------------
module lbct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lbct_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output lbct_pkg::job_t pop_job,
	output logic           nonempty
);
	import lbct_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign nonempty = count_q != '0;
	assign pop_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/lbct_back.sv
// ----------------------------------------------------------------------------
// lbct_back
// Reads the slot's counter, applies the add or subtract, keeps the running
// total and holds the result in an output register.
// ----------------------------------------------------------------------------
module lbct_back (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        pop,
	input  lbct_pkg::job_t              pop_job,
	input  logic                        q_nonempty,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lbct_pkg::CNT_W-1:0]  prior_bytes,
	output logic [lbct_pkg::CNT_W-1:0]  total_bytes,
	output logic [1:0]                  status
);
	import lbct_pkg::*;

	logic             valid_s2;
	job_t             job_s2;
	logic [CNT_W-1:0] cnt_rd_s2;

	logic [CNT_W-1:0] cnt_mem [CAPACITY];
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] prior_q;
	status_t          status_q;

	logic             out_free;
	logic             fire;
	logic             wr_en;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] amt_ext;
	logic [CNT_W-1:0] new_cnt;
	logic [CNT_W-1:0] new_total;
	logic [CNT_W-1:0] prior;
	status_t          stat;

	// A job is read only after the previous write has landed, so the
	// counter read never sees a stale value.
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s2 && out_free;
	assign pop      = q_nonempty && !valid_s2;

	assign out_valid   = out_valid_q;
	assign prior_bytes = prior_q;
	assign total_bytes = total_q;
	assign status      = status_q;

	always_comb begin
		// A freshly allocated slot holds no valid data yet and counts as zero.
		cur       = job_s2.fresh ? '0 : cnt_rd_s2;
		amt_ext   = CNT_W'(job_s2.amount);
		new_cnt   = cur;
		new_total = total_q;
		prior     = '0;
		stat      = STAT_OK;
		wr_en     = 1'b0;
		unique case (job_s2.kind)
			KIND_PASS: begin
				stat = STAT_OK;
			end
			KIND_FULL: begin
				stat = STAT_FULL;
			end
			KIND_SLOT: begin
				prior = cur;
				wr_en = 1'b1;
				unique case (job_s2.action)
					ACT_ADD: begin
						new_cnt   = cur + amt_ext;
						new_total = total_q + amt_ext;
					end
					ACT_SUB: begin
						if (cur < amt_ext) begin
							stat = STAT_UNDER;
						end else begin
							new_cnt   = cur - amt_ext;
							new_total = total_q - amt_ext;
						end
					end
					ACT_QLABEL, ACT_QTOTAL: begin
						new_cnt = cur;
					end
				endcase
			end
			default: begin
				stat = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				total_q     <= new_total;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s2    <= pop_job;
			cnt_rd_s2 <= cnt_mem[pop_job.slot];
		end
		if (fire && wr_en) begin
			cnt_mem[job_s2.slot] <= new_cnt;
		end
		if (fire) begin
			prior_q  <= prior;
			status_q <= stat;
		end
	end

endmodule

// File: rtl/labelled_byte_counter_table_unit.sv
// ----------------------------------------------------------------------------
// labelled_byte_counter_table_unit
// A request passes the front-end register, the job queue, the back-end register
// and the output register. The front end takes no new request until its label
// map lookup and allocation are done, and the back end pops no new job until
// its counter read-modify-write is done. Reset clears the label valid bits, the
// fill count, the running total and all handshake state; counters need no
// clearing pass as a freshly allocated slot reads as zero until first written.
// ----------------------------------------------------------------------------
module labelled_byte_counter_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [lbct_pkg::TAG_BITS-1:0]  tag,
	input  logic [lbct_pkg::AMT_W-1:0]     amount,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lbct_pkg::CNT_W-1:0]     prior_bytes,
	output logic [lbct_pkg::CNT_W-1:0]     total_bytes,
	output logic [1:0]                     status
);
	import lbct_pkg::*;

	logic push;
	logic q_full;
	logic pop;
	logic q_nonempty;
	job_t push_job;
	job_t pop_job;

	lbct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.tag      (tag),
		.amount   (amount),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	lbct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.nonempty (q_nonempty)
	);

	lbct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_job     (pop_job),
		.q_nonempty  (q_nonempty),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prior_bytes (prior_bytes),
		.total_bytes (total_bytes),
		.status      (status)
	);

	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("job pushed into a full queue");

	a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !q_nonempty))
		else $error("job popped from an empty queue");

	a_full_reports_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_FULL) |-> prior_bytes == '0)
		else $error("full-table result carries a non-zero prior count");

endmodule
